### rtl/ssks_pkg.sv
// shared types and constants for the sparse sorted key search block
// table geometry, request and response payload structs, table port struct
// no dependencies
package ssks_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_CHARS   = 8;
    localparam int KEY_W       = 64;
    localparam int ADDR_W      = 8;
    localparam int COUNT_W     = 9;
    // signed index wide enough for mid +/- distance and for -1
    localparam int IDX_W       = COUNT_W + 2;

    // characters beyond KEY_CHARS are cleared before use
    localparam logic [KEY_W-1:0] KEY_MASK =
        ~({KEY_W{1'b1}} >> (8 * KEY_CHARS));

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef logic signed [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] entry_index;
        logic [KEY_W-1:0]  entry_key;
        logic [KEY_W-1:0]  search_key;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] position;
    } res_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } tbl_req_t;

endpackage

### rtl/ssks_table.sv
// key table: one write port and one read port, read data registered
// depends on ssks_pkg
module ssks_table
    import ssks_pkg::*;
(
    input  logic             clk,
    input  tbl_req_t         tbl,
    output logic [KEY_W-1:0] rd_data
);

    logic [KEY_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (tbl.wr_en)
        begin
            mem[tbl.wr_addr] <= tbl.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl.rd_en)
        begin
            rd_data <= mem[tbl.rd_addr];
        end
    end

endmodule

### rtl/sparse_sorted_key_search.sv
// sparse sorted key search: binary search over a sorted key table with empty entries
// load request: no response; search: response valid once its table reads are done, and the next
// request is taken after that; table reads (probes plus scan steps) are issued one a cycle
// one request in flight; a search also waits while the previous response is still unaccepted
// rst_n (async, active low) clears control state and entry_count; table holds no reset
// depends on ssks_pkg and ssks_table
module sparse_sorted_key_search
    import ssks_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req_data,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res_data
);

    // S_MID, S_RIGHT, S_LEFT: table data for the address issued last cycle is present
    typedef enum logic [2:0] {
        S_IDLE,
        S_MID,
        S_RIGHT,
        S_LEFT,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    idx_t               lo_reg, lo_next;
    idx_t               hi_reg, hi_next;
    idx_t               mid_reg, mid_next;
    idx_t               dist_reg, dist_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    res_t               hold_reg, hold_next;
    logic               res_valid_reg, res_valid_next;
    res_t               res_reg, res_next;

    tbl_req_t           tbl;
    logic [KEY_W-1:0]   rd_data;

    // working signals of the search step
    logic               accept;
    logic [COUNT_W-1:0] n_clamp;
    idx_t               hi_start;
    logic               eval_go;
    idx_t               eval_idx;
    idx_t               eval_lo;
    idx_t               eval_hi;
    logic               scan_go;
    idx_t               scan_dist;
    idx_t               scan_l;
    idx_t               scan_r;
    idx_t               left_idx;
    idx_t               right_idx;

    ssks_table u_table (
        .clk     (clk),
        .tbl     (tbl),
        .rd_data (rd_data)
    );

    // one request at a time; a pending response does not hold off the next request
    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // entry_count above the table depth searches the whole table
    assign n_clamp  = (count_reg > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : count_reg;
    assign hi_start = idx_t'({1'b0, n_clamp}) - idx_t'(1);

    assign right_idx = mid_reg + dist_reg;
    assign left_idx  = mid_reg - dist_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        dist_next      = dist_reg;
        key_next       = key_reg;
        hold_next      = hold_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        tbl.wr_en   = 1'b0;
        tbl.wr_addr = req_data.entry_index;
        tbl.wr_data = req_data.entry_key & KEY_MASK;
        tbl.rd_en   = 1'b0;
        tbl.rd_addr = mid_reg[ADDR_W-1:0];

        eval_go   = 1'b0;
        eval_idx  = mid_reg;
        eval_lo   = lo_reg;
        eval_hi   = hi_reg;
        scan_go   = 1'b0;
        scan_dist = dist_reg;
        scan_l    = '0;
        scan_r    = '0;

        // response register drains independently of the search
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            count_next = cfg_wr_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_data.mode == MODE_LOAD)
                    begin
                        // loads beyond the table are dropped
                        tbl.wr_en = (32'(req_data.entry_index) < TABLE_DEPTH);
                    end
                    else
                    begin
                        key_next = req_data.search_key & KEY_MASK;
                        lo_next  = '0;
                        hi_next  = hi_start;
                        if (hi_start < idx_t'(0))
                        begin
                            // empty range: nothing to find
                            hold_next  = '0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            mid_next    = hi_start >>> 1;
                            tbl.rd_en   = 1'b1;
                            tbl.rd_addr = mid_next[ADDR_W-1:0];
                            state_next  = S_MID;
                        end
                    end
                end
            end

            S_MID:
            begin
                // an empty midpoint still matches an empty search key
                if (rd_data == key_reg || rd_data != '0)
                begin
                    eval_go  = 1'b1;
                    eval_idx = mid_reg;
                end
                else
                begin
                    scan_go   = 1'b1;
                    scan_dist = idx_t'(1);
                end
            end

            S_RIGHT:
            begin
                if (rd_data != '0)
                begin
                    eval_go  = 1'b1;
                    eval_idx = right_idx;
                end
                else if (left_idx >= lo_reg)
                begin
                    tbl.rd_en   = 1'b1;
                    tbl.rd_addr = left_idx[ADDR_W-1:0];
                    state_next  = S_LEFT;
                end
                else
                begin
                    scan_go   = 1'b1;
                    scan_dist = dist_reg + idx_t'(1);
                end
            end

            S_LEFT:
            begin
                if (rd_data != '0)
                begin
                    eval_go  = 1'b1;
                    eval_idx = left_idx;
                end
                else
                begin
                    scan_go   = 1'b1;
                    scan_dist = dist_reg + idx_t'(1);
                end
            end

            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    res_next       = hold_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // compare a non-empty entry, or an empty one that equals the key, and report a match or narrow the range
        if (eval_go)
        begin
            if (rd_data == key_reg)
            begin
                hold_next.found    = 1'b1;
                hold_next.position = eval_idx[ADDR_W-1:0];
                state_next         = S_DONE;
            end
            else
            begin
                if (rd_data < key_reg)
                begin
                    eval_lo = eval_idx + idx_t'(1);
                end
                else
                begin
                    eval_hi = eval_idx - idx_t'(1);
                end
                lo_next = eval_lo;
                hi_next = eval_hi;
                if (eval_lo > eval_hi)
                begin
                    hold_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    mid_next    = eval_lo + ((eval_hi - eval_lo) >>> 1);
                    tbl.rd_en   = 1'b1;
                    tbl.rd_addr = mid_next[ADDR_W-1:0];
                    state_next  = S_MID;
                end
            end
        end

        // outward scan step: right side first at equal distance
        if (scan_go)
        begin
            scan_l    = mid_reg - scan_dist;
            scan_r    = mid_reg + scan_dist;
            dist_next = scan_dist;
            if (scan_l < lo_reg && scan_r > hi_reg)
            begin
                hold_next  = '0;
                state_next = S_DONE;
            end
            else if (scan_r <= hi_reg)
            begin
                tbl.rd_en   = 1'b1;
                tbl.rd_addr = scan_r[ADDR_W-1:0];
                state_next  = S_RIGHT;
            end
            else
            begin
                tbl.rd_en   = 1'b1;
                tbl.rd_addr = scan_l[ADDR_W-1:0];
                state_next  = S_LEFT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            dist_reg      <= '0;
            key_reg       <= '0;
            hold_reg      <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            dist_reg      <= dist_next;
            key_reg       <= key_next;
            hold_reg      <= hold_next;
            res_reg       <= res_next;
        end
    end

endmodule

### rtl/ssks_check.sv
// port-level checks for the sparse sorted key search block, bound to the top level
// depends on ssks_pkg and sparse_sorted_key_search
module ssks_check
    import ssks_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_wr_en,
    input logic [COUNT_W-1:0] cfg_wr_data,
    input logic               req_valid,
    input logic               req_ready,
    input req_t               req_data,
    input logic               res_valid,
    input logic               res_ready,
    input res_t               res_data
);

    // a stalled response holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("response changed while stalled");

    // a miss always reports position zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.found |-> res_data.position == '0)
        else $error("miss with non-zero position");

    // a load request never makes a response appear
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_data.mode == MODE_LOAD && !res_valid |=> !res_valid)
        else $error("response after load request");

    // a search request leaves the block busy, with req_ready low, right after it is taken
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_data.mode == MODE_SEARCH |=> !req_ready)
        else $error("request taken right after a search request");

endmodule

bind sparse_sorted_key_search ssks_check u_ssks_check (.*);

### bench/tb.sv
// self-checking bench for sparse_sorted_key_search: directed table, then random phases
// of sorted sparse table builds and searches, checked against an in-bench search model
// depends on ssks_pkg and the sparse_sorted_key_search rtl
module tb;
    import ssks_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int CFG_SETTLE   = 8;
    localparam int DRAIN_CYCLES = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int ITEM_TARGET  = 1400;

    localparam logic [KEY_W-1:0] KEY_ONES = '1;
    // "midkey" packed big-endian, zero padded
    localparam logic [KEY_W-1:0] KEY_MID  = 64'h6D69_646B_6579_0000;
    localparam logic [KEY_W-1:0] KEY_P    = 64'h7000_0000_0000_0000;
    localparam logic [KEY_W-1:0] KEY_Q    = 64'h7100_0000_0000_0000;

    typedef enum logic {STEP_REQUEST, STEP_CONFIG} step_kind_t;

    typedef struct packed {
        step_kind_t         kind;
        logic [COUNT_W-1:0] count;
        req_t               req;
        logic               typed;
        res_t               want;
    } plan_row_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;
    logic               req_valid   = 1'b0;
    logic               req_ready;
    req_t               req_data    = '0;
    logic               res_valid;
    logic               res_ready   = 1'b0;
    res_t               res_data;

    // bench copy of the block state
    logic [KEY_W-1:0]   stored_keys [TABLE_DEPTH];
    logic [COUNT_W-1:0] entry_count_q = '0;

    // answers owed by the block, oldest first
    res_t awaited_answers [$];

    int mismatches    = 0;
    int items_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    sparse_sorted_key_search u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_data    (req_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // unused fields carry random junk so the block has to ignore them
    function automatic req_t load_req(input int idx, input logic [KEY_W-1:0] key);
        req_t r;
        r.mode        = MODE_LOAD;
        r.entry_index = ADDR_W'(idx);
        r.entry_key   = key;
        r.search_key  = rand_key();
        return r;
    endfunction

    function automatic req_t search_req(input logic [KEY_W-1:0] key);
        req_t r;
        r.mode        = MODE_SEARCH;
        r.entry_index = ADDR_W'($urandom);
        r.entry_key   = rand_key();
        r.search_key  = key;
        return r;
    endfunction

    function automatic plan_row_t load_row(input int idx, input logic [KEY_W-1:0] key);
        return '{STEP_REQUEST, '0, load_req(idx, key), 1'b0, '0};
    endfunction

    function automatic plan_row_t search_row(input logic [KEY_W-1:0] key, input logic typed,
                                             input logic found, input int pos);
        return '{STEP_REQUEST, '0, search_req(key), typed, '{found, ADDR_W'(pos)}};
    endfunction

    function automatic plan_row_t count_row(input int value);
        return '{STEP_CONFIG, COUNT_W'(value), '0, 1'b0, '0};
    endfunction

    // binary search with an outward hunt (right side first) when the probe is empty
    function automatic res_t predict_search(input logic [KEY_W-1:0] key);
        int lo;
        int hi;
        int mid;
        int d;
        int l;
        int r;
        bit hunting;
        lo = 0;
        if (entry_count_q > TABLE_DEPTH)
            hi = TABLE_DEPTH - 1;
        else
            hi = int'(entry_count_q) - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            // an empty probe matches an empty search key
            if (stored_keys[mid] == key)
                return '{1'b1, ADDR_W'(mid)};
            if (stored_keys[mid] == '0)
            begin
                d = 1;
                hunting = 1'b1;
                while (hunting)
                begin
                    l = mid - d;
                    r = mid + d;
                    // nothing left in range on either side
                    if (l < lo && r > hi)
                        return '{1'b0, '0};
                    if (r <= hi && stored_keys[r] != '0)
                    begin
                        mid = r;
                        hunting = 1'b0;
                    end
                    else if (l >= lo && stored_keys[l] != '0)
                    begin
                        mid = l;
                        hunting = 1'b0;
                    end
                    else
                        d++;
                end
            end
            if (stored_keys[mid] == key)
                return '{1'b1, ADDR_W'(mid)};
            if (stored_keys[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return '{1'b0, '0};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic check_answer(input res_t got);
        res_t want;
        if (awaited_answers.size() == 0)
            report_mismatch($sformatf("response with no request outstanding, found=%0b position=%0d",
                                      got.found, got.position));
        else
        begin
            want = awaited_answers.pop_front();
            if (got.found !== want.found)
                report_mismatch($sformatf("found %0b, wanted %0b", got.found, want.found));
            if (got.position !== want.position)
                report_mismatch($sformatf("position %0d, wanted %0d", got.position, want.position));
        end
    endtask

    // one request: optional idle gap, then hold valid until taken; valid is left high
    // after acceptance
    task automatic push_request(input req_t r, input bit typed, input res_t want);
        // idling pattern moves on with the request count
        if (items_sent < ITEM_TARGET / 3)
        begin
            send_idle_pct = 27;
            recv_idle_pct = 74;
        end
        else if (items_sent < 2 * ITEM_TARGET / 3)
        begin
            send_idle_pct = 74;
            recv_idle_pct = 27;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (!req_ready);
        items_sent++;
        // loads update the bench table, searches owe one response
        if (r.mode == MODE_LOAD)
            stored_keys[r.entry_index] = r.entry_key & KEY_MASK;
        else if (typed)
            awaited_answers.push_back(want);
        else
            awaited_answers.push_back(predict_search(r.search_key & KEY_MASK));
    endtask

    // sender goes quiet until every response is in and any load has settled
    task automatic drain_block();
        req_valid <= 1'b0;
        while (awaited_answers.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
    endtask

    task automatic set_entry_count(input logic [COUNT_W-1:0] value);
        drain_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        entry_count_q = value;
    endtask

    // response side: check on handshake, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            check_answer(res_data);
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        // long hold-off lets the block fill and back-pressure the request side
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        plan_row_t        plan [$];
        int               phase;
        int               span;
        int               empty_pct;
        int               n_search;
        int               pick;
        int               idx;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] stride;
        logic [KEY_W-1:0] last_key;
        logic [COUNT_W-1:0] count;
        bit               at_top;
        bit               big_done;

        // directed table; typed answers only where obvious
        plan.push_back(search_row('0, 1'b1, 1'b0, 0));          // zero count
        plan.push_back(search_row(KEY_ONES, 1'b1, 1'b0, 0));    // zero count
        plan.push_back(load_row(0, 64'h1));                    // smallest key
        plan.push_back(load_row(100, KEY_MID));
        plan.push_back(load_row(255, KEY_ONES));               // largest key, last slot
        plan.push_back(count_row(TABLE_DEPTH));
        plan.push_back(search_row(KEY_ONES, 1'b1, 1'b1, 255));
        plan.push_back(search_row(64'h1, 1'b1, 1'b1, 0));
        plan.push_back(search_row(KEY_MID, 1'b1, 1'b1, 100));
        plan.push_back(search_row('0, 1'b1, 1'b1, 127));       // empty key meets empty midpoint
        plan.push_back(search_row(64'h2, 1'b0, 1'b0, 0));      // absent, between neighbours
        plan.push_back(load_row(126, KEY_P));                  // equal distance either side of 127
        plan.push_back(load_row(128, KEY_Q));
        plan.push_back(search_row(KEY_P, 1'b0, 1'b0, 0));
        plan.push_back(search_row(KEY_Q, 1'b0, 1'b0, 0));
        plan.push_back(count_row(1));
        plan.push_back(search_row(64'h1, 1'b1, 1'b1, 0));
        plan.push_back(search_row(KEY_ONES, 1'b1, 1'b0, 0));
        plan.push_back(load_row(0, '0));
        plan.push_back(count_row(5));
        plan.push_back(search_row(64'h5, 1'b1, 1'b0, 0));      // whole range empty
        plan.push_back(count_row(511));                        // count clamps to table depth
        plan.push_back(search_row(KEY_ONES, 1'b1, 1'b1, 255));
        plan.push_back(count_row(257));
        plan.push_back(search_row(KEY_MID, 1'b0, 1'b0, 0));
        plan.push_back(search_row(64'hAAAA_5555_AAAA_5555, 1'b0, 1'b0, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every slot gets written once so that no search ever reads an unwritten entry
        for (int i = 0; i < TABLE_DEPTH; i++)
            push_request(load_req(i, '0), 1'b0, '0);

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_CONFIG)
                set_entry_count(plan[i].count);
            else
                push_request(plan[i].req, plan[i].typed, plan[i].want);
        end

        // random phases: set a count, build a sorted sparse table, search it
        phase = 0;
        big_done = 1'b0;
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                count = COUNT_W'($urandom_range(0, 2));
            else if (pick < 16)
                count = COUNT_W'(TABLE_DEPTH);
            else if (pick < 18)
                count = COUNT_W'(511);
            else if (pick < 20)
                count = COUNT_W'($urandom_range(257, 510));
            else if (pick < 28)
                count = COUNT_W'($urandom_range(3, 255));
            else
                count = COUNT_W'($urandom_range(3, 24));
            set_entry_count(count);
            span = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);

            // wide tables are rebuilt only once, otherwise searched as they stand
            if (span <= 64 || !big_done)
            begin
                if (span > 64)
                    big_done = 1'b1;
                empty_pct = ($urandom_range(9) == 0) ? 100 : $urandom_range(0, 90);
                if ($urandom_range(1) == 0)
                    last_key = KEY_W'($urandom_range(1, 1000));
                else
                    last_key = rand_key() >> $urandom_range(1, 8);
                at_top = 1'b0;
                for (int i = 0; i < span; i++)
                begin
                    // occasional stray load breaks the ordering
                    if ($urandom_range(99) < 3)
                        push_request(load_req($urandom_range(0, 255), rand_key()), 1'b0, '0);
                    if (at_top || $urandom_range(99) < empty_pct)
                        key = '0;
                    else if (i == span - 1 && $urandom_range(3) == 0)
                        key = KEY_ONES;
                    else
                    begin
                        stride = (rand_key() >> $urandom_range(4, 63)) + 1;
                        key = last_key + stride;
                        // wrapped past the top: rest of the table stays empty
                        if (key <= last_key)
                        begin
                            key = '0;
                            at_top = 1'b1;
                        end
                        else
                            last_key = key;
                    end
                    push_request(load_req(i, key), 1'b0, '0);
                end
            end

            if (phase == 2)
                hold_request = HOLD_CYCLES;
            n_search = $urandom_range(8, 30);
            for (int s = 0; s < n_search; s++)
            begin
                pick = $urandom_range(99);
                idx = (span > 0) ? $urandom_range(0, span - 1) : 0;
                if (pick < 40)
                    key = stored_keys[idx];
                else if (pick < 50)
                    key = stored_keys[idx] + 64'd1;
                else if (pick < 60)
                    key = stored_keys[idx] - 64'd1;
                else if (pick < 70)
                    key = '0;
                else if (pick < 75)
                    key = KEY_ONES;
                else
                    key = rand_key();
                push_request(search_req(key), 1'b0, '0);
                if ($urandom_range(99) < 4)
                    push_request(load_req($urandom_range(0, 255), rand_key()), 1'b0, '0);
                if ($urandom_range(99) < 2)
                    drain_block();
            end
            phase++;
        end

        drain_block();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
